FILE: rtl/core/quaternion_to_euler_top_assert.svh
// ----------------------------------------------------------------------------
// Quaternion to Euler assertion macros
// Concurrent checks used by the quaternion to Euler top module.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_TOP_ASSERT_SVH
`define QUATERNION_TO_EULER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define Q2E_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define Q2E_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/q2e_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler package
// Widths, angle constants and helper functions of the conversion pipeline.
// ----------------------------------------------------------------------------
package q2e_pkg;

    localparam int QW        = 16;   // quaternion component
    localparam int PW        = 2 * QW;
    localparam int SUM_W     = 36;   // cross terms, scaled by 2^30
    localparam int SPW       = 30;   // |sp| below one
    localparam int CW        = 46;   // CORDIC x/y datapath
    localparam int ZW        = 33;   // angle, Q3.29
    localparam int SHW       = 6;
    localparam int NORM_MSB  = 40;
    localparam int ISQ_W     = 61;
    localparam int ISQ_STEPS = 31;
    localparam int ROOT_W    = 31;
    localparam int RW        = 16;   // roll / yaw output
    localparam int PTW       = 15;   // pitch output
    localparam int RND_W     = 18;

    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic signed [SUM_W-1:0] ONE_Q30     = SUM_W'(64'sd1073741824);
    localparam logic signed [SUM_W-1:0] NEG_ONE_Q30 = -ONE_Q30;
    localparam logic [ISQ_W-1:0]        ISQ_TOP     = ISQ_W'(1) << (ISQ_W - 1);
    localparam logic signed [ZW-1:0]    ANG_HALF_PI = ZW'(64'sd843314857);
    localparam logic signed [RND_W-1:0] OUT_PI      = RND_W'(25736);
    localparam logic signed [RND_W-1:0] OUT_HALF_PI = RND_W'(12868);

    function automatic logic signed [ZW-1:0] atan_step(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0:       a = ZW'(64'sd421657428);
            1:       a = ZW'(64'sd248918915);
            2:       a = ZW'(64'sd131521918);
            3:       a = ZW'(64'sd66762579);
            4:       a = ZW'(64'sd33510843);
            5:       a = ZW'(64'sd16771758);
            6:       a = ZW'(64'sd8387925);
            7:       a = ZW'(64'sd4194219);
            8:       a = ZW'(64'sd2097141);
            9:       a = ZW'(64'sd1048575);
            default: a = ZW'(64'sd524288) >>> (i - 10);
        endcase
        return a;
    endfunction

    // left shift that brings the leading one of m to bit NORM_MSB
    function automatic logic [SHW-1:0] norm_shift(input logic [SUM_W-1:0] m);
        int pos;
        pos = 0;
        for (int b = 0; b < SUM_W; b++)
        begin
            if (m[b])
                pos = b;
        end
        return SHW'(NORM_MSB - pos);
    endfunction

endpackage

FILE: rtl/core/quaternion_to_euler_top.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles (ZYX)
// Unit quaternion in Q1.15 to roll and yaw in Q3.13 and pitch in Q2.13 radians.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   w, x, y, z (16 b each)
//  m_axis    out  m_axis_tvalid/m_axis_tready   roll 16 b, pitch 15 b, yaw 16 b
//
//  One request per cycle while the output is not stalled. The pipeline holds
//  four product/sum stages, 31 square-root stages, two normalize stages and
//  one stage per CORDIC step, then the rounding output register.
//  Reset clears only the valid bits.
//  A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module quaternion_to_euler_top
#(
    parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // roll_angle, pitch_angle, yaw_angle, pad
);

    localparam int QW   = q2e_pkg::QW;
    localparam int PW   = q2e_pkg::PW;
    localparam int SW   = q2e_pkg::SUM_W;
    localparam int SPW  = q2e_pkg::SPW;
    localparam int NSQ  = q2e_pkg::ISQ_STEPS;
    localparam int ALAT = CORDIC_STEPS + 2;
    localparam int ZW   = q2e_pkg::ZW;
    localparam int RNW  = q2e_pkg::RND_W;

    typedef struct packed {
        logic signed [SW-1:0] sr;
        logic signed [SW-1:0] cr;
        logic signed [SW-1:0] sp;
        logic signed [SW-1:0] sy;
        logic signed [SW-1:0] cy;
        logic                 satp;
        logic                 satn;
    } side_t;

    function automatic logic signed [RNW-1:0] round_clamp(
        input logic signed [ZW-1:0]  z,
        input logic signed [RNW-1:0] lim
    );
        logic signed [ZW:0]    sum;
        logic signed [RNW-1:0] r;
        sum = (ZW + 1)'(z) + (ZW + 1)'(32768);
        r   = RNW'(sum >>> 16);
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r;
    endfunction

    logic ce;
    logic m_valid_reg;

    assign ce            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = ce;

    // stage 1: products
    logic signed [QW-1:0] qw, qx, qy, qz;
    logic signed [PW-1:0] p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_wy_reg;
    logic signed [PW-1:0] p_zx_reg, p_wz_reg, p_xy_reg, p_zz_reg;
    logic                 v1_reg;

    always_comb
    begin
        qw = s_axis_tdata[15:0];
        qx = s_axis_tdata[31:16];
        qy = s_axis_tdata[47:32];
        qz = s_axis_tdata[63:48];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p_wx_reg <= PW'(qw) * PW'(qx);
            p_yz_reg <= PW'(qy) * PW'(qz);
            p_xx_reg <= PW'(qx) * PW'(qx);
            p_yy_reg <= PW'(qy) * PW'(qy);
            p_wy_reg <= PW'(qw) * PW'(qy);
            p_zx_reg <= PW'(qz) * PW'(qx);
            p_wz_reg <= PW'(qw) * PW'(qz);
            p_xy_reg <= PW'(qx) * PW'(qy);
            p_zz_reg <= PW'(qz) * PW'(qz);
        end
    end

    // stage 2: cross terms
    logic signed [SW-1:0] sr2_reg, cr2_reg, sp2_reg, sy2_reg, cy2_reg;
    logic                 v2_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sr2_reg <= (SW'(p_wx_reg) + SW'(p_yz_reg)) <<< 1;
            cr2_reg <= q2e_pkg::ONE_Q30 - ((SW'(p_xx_reg) + SW'(p_yy_reg)) <<< 1);
            sp2_reg <= (SW'(p_wy_reg) - SW'(p_zx_reg)) <<< 1;
            sy2_reg <= (SW'(p_wz_reg) + SW'(p_xy_reg)) <<< 1;
            cy2_reg <= q2e_pkg::ONE_Q30 - ((SW'(p_yy_reg) + SW'(p_zz_reg)) <<< 1);
        end
    end

    // stage 3: pitch limit and sp squared
    logic                 satp3_next, satn3_next;
    logic [SW-1:0]        sp_abs;
    logic [SPW-1:0]       sp_mag;
    logic [2*SPW-1:0]     sq3_reg;
    side_t                side3_reg;
    logic                 v3_reg;

    always_comb
    begin
        satp3_next = sp2_reg >= q2e_pkg::ONE_Q30;
        satn3_next = sp2_reg <= q2e_pkg::NEG_ONE_Q30;
        sp_abs     = sp2_reg[SW-1] ? SW'(-sp2_reg) : SW'(sp2_reg);
        sp_mag     = (satp3_next || satn3_next) ? '0 : sp_abs[SPW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sq3_reg <= (2 * SPW)'(sp_mag) * (2 * SPW)'(sp_mag);
            side3_reg <= '{sr: sr2_reg, cr: cr2_reg, sp: sp2_reg, sy: sy2_reg,
                           cy: cy2_reg, satp: satp3_next, satn: satn3_next};
        end
    end

    // stage 4: radicand 1 - sp^2
    logic [q2e_pkg::ISQ_W-1:0] n4_reg;
    logic                      v4_reg;
    side_t                     side_reg [0:NSQ];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            n4_reg      <= q2e_pkg::ISQ_TOP - q2e_pkg::ISQ_W'(sq3_reg);
            side_reg[0] <= side3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (ce)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    logic                       sq_valid;
    logic [q2e_pkg::ROOT_W-1:0] root;

    q2e_isqrt u_isqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v4_reg),
        .in_n      (n4_reg),
        .out_valid (sq_valid),
        .out_root  (root)
    );

    // hold the cross terms alongside the root
    genvar k;
    generate
        for (k = 0; k < NSQ; k++)
        begin : g_side
            always_ff @(posedge clk)
            begin
                if (ce)
                    side_reg[k+1] <= side_reg[k];
            end
        end
    endgenerate

    side_t                side_end;
    logic signed [SW-1:0] cp;

    always_comb
    begin
        side_end = side_reg[NSQ];
        cp       = SW'(root);
    end

    logic                 roll_valid, pitch_valid, yaw_valid;
    logic signed [ZW-1:0] roll_z, pitch_z, yaw_z;

    q2e_atan2 #(.STEPS(CORDIC_STEPS)) u_roll
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (sq_valid),
        .in_y      (side_end.sr),
        .in_x      (side_end.cr),
        .out_valid (roll_valid),
        .out_angle (roll_z)
    );

    q2e_atan2 #(.STEPS(CORDIC_STEPS)) u_pitch
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (sq_valid),
        .in_y      (side_end.sp),
        .in_x      (cp),
        .out_valid (pitch_valid),
        .out_angle (pitch_z)
    );

    q2e_atan2 #(.STEPS(CORDIC_STEPS)) u_yaw
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (sq_valid),
        .in_y      (side_end.sy),
        .in_x      (side_end.cy),
        .out_valid (yaw_valid),
        .out_angle (yaw_z)
    );

    // pitch limit flags ride along the CORDIC latency: bit 1 positive, bit 0 negative
    logic [1:0] sat_reg [0:ALAT];

    always_comb
    begin
        sat_reg[0] = {side_end.satp, side_end.satn};
    end

    generate
        for (k = 0; k < ALAT; k++)
        begin : g_sat
            always_ff @(posedge clk)
            begin
                if (ce)
                    sat_reg[k+1] <= sat_reg[k];
            end
        end
    endgenerate

    // output stage: round, clamp, override saturated pitch
    logic signed [RNW-1:0] roll_r, pitch_r, yaw_r, pitch_sel;
    logic signed [q2e_pkg::RW-1:0]  roll_reg, yaw_reg;
    logic signed [q2e_pkg::PTW-1:0] pitch_reg;

    always_comb
    begin
        roll_r  = round_clamp(roll_z, q2e_pkg::OUT_PI);
        yaw_r   = round_clamp(yaw_z, q2e_pkg::OUT_PI);
        pitch_r = round_clamp(pitch_z, q2e_pkg::OUT_HALF_PI);
        if (sat_reg[ALAT][1])
            pitch_sel = q2e_pkg::OUT_HALF_PI;
        else if (sat_reg[ALAT][0])
            pitch_sel = -q2e_pkg::OUT_HALF_PI;
        else
            pitch_sel = pitch_r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (ce)
            m_valid_reg <= roll_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            roll_reg  <= roll_r[q2e_pkg::RW-1:0];
            pitch_reg <= pitch_sel[q2e_pkg::PTW-1:0];
            yaw_reg   <= yaw_r[q2e_pkg::RW-1:0];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, yaw_reg, pitch_reg, roll_reg};

`include "quaternion_to_euler_top_assert.svh"

    `Q2E_ASSERT_IMP(a_lanes_aligned, roll_valid, pitch_valid && yaw_valid, "CORDIC lanes out of step")
    `Q2E_ASSERT_NXT(a_pitch_sat, ce && roll_valid && sat_reg[ALAT][1], pitch_reg == 15'sd12868, "saturated pitch not +pi/2")
    `Q2E_ASSERT_IMP(a_roll_range, m_valid_reg, (roll_reg <= 16'sd25736) && (roll_reg >= -16'sd25736), "roll out of range")
    `Q2E_ASSERT_IMP(a_yaw_range, m_valid_reg, (yaw_reg <= 16'sd25736) && (yaw_reg >= -16'sd25736), "yaw out of range")

endmodule

FILE: rtl/core/q2e_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module q2e_isqrt
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         ce,
    input  logic                         in_valid,
    input  logic [q2e_pkg::ISQ_W-1:0]    in_n,
    output logic                         out_valid,
    output logic [q2e_pkg::ROOT_W-1:0]   out_root
);

    localparam int W = q2e_pkg::ISQ_W;
    localparam int N = q2e_pkg::ISQ_STEPS;

    logic [W-1:0] n_reg [0:N];
    logic [W-1:0] r_reg [0:N];
    logic         v_reg [0:N];

    always_comb
    begin
        n_reg[0] = in_n;
        r_reg[0] = '0;
        v_reg[0] = in_valid;
    end

    genvar j;
    generate
        for (j = 0; j < N; j++)
        begin : g_step
            localparam logic [W:0] BIT = (W + 1)'(1) << (W - 1 - 2 * j);
            logic [W:0]   trial;
            logic [W-1:0] n_next;
            logic [W-1:0] r_next;

            always_comb
            begin
                trial = {1'b0, r_reg[j]} + BIT;
                if ({1'b0, n_reg[j]} >= trial)
                begin
                    n_next = n_reg[j] - trial[W-1:0];
                    r_next = (r_reg[j] >> 1) + BIT[W-1:0];
                end
                else
                begin
                    n_next = n_reg[j];
                    r_next = r_reg[j] >> 1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[j+1] <= 1'b0;
                else if (ce)
                    v_reg[j+1] <= v_reg[j];
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    n_reg[j+1] <= n_next;
                    r_reg[j+1] <= r_next;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[N];
    assign out_root  = r_reg[N][q2e_pkg::ROOT_W-1:0];

endmodule

FILE: rtl/core/q2e_atan2.sv
// ----------------------------------------------------------------------------
// Pipelined CORDIC atan2
// Normalize, fold into the right half plane, then one vectoring step a stage.
// ----------------------------------------------------------------------------
module q2e_atan2
#(
    parameter int STEPS = q2e_pkg::CORDIC_STEPS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              ce,
    input  logic                              in_valid,
    input  logic signed [q2e_pkg::SUM_W-1:0]  in_y,
    input  logic signed [q2e_pkg::SUM_W-1:0]  in_x,
    output logic                              out_valid,
    output logic signed [q2e_pkg::ZW-1:0]     out_angle
);

    localparam int SW = q2e_pkg::SUM_W;
    localparam int CW = q2e_pkg::CW;
    localparam int ZW = q2e_pkg::ZW;

    // normalize stage
    logic [SW-1:0]             ax;
    logic [SW-1:0]             ay;
    logic signed [SW-1:0]      x1_reg;
    logic signed [SW-1:0]      y1_reg;
    logic [q2e_pkg::SHW-1:0]   sh1_reg;
    logic                      zero1_reg;
    logic                      v1_reg;

    always_comb
    begin
        ax = in_x[SW-1] ? SW'(-in_x) : SW'(in_x);
        ay = in_y[SW-1] ? SW'(-in_y) : SW'(in_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (ce)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x1_reg    <= in_x;
            y1_reg    <= in_y;
            sh1_reg   <= q2e_pkg::norm_shift(ax | ay);
            zero1_reg <= (in_x == '0) && (in_y == '0);
        end
    end

    logic signed [CW-1:0] cx_reg [0:STEPS];
    logic signed [CW-1:0] cy_reg [0:STEPS];
    logic signed [ZW-1:0] cz_reg [0:STEPS];
    logic                 cv_reg [0:STEPS];
    logic                 c0_reg [0:STEPS];

    // shift and quadrant fold
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] xf_next;
    logic signed [CW-1:0] yf_next;
    logic signed [ZW-1:0] zf_next;

    always_comb
    begin
        xs = CW'(x1_reg) <<< sh1_reg;
        ys = CW'(y1_reg) <<< sh1_reg;
        if (xs < 0)
        begin
            if (ys >= 0)
            begin
                xf_next = ys;
                yf_next = -xs;
                zf_next = q2e_pkg::ANG_HALF_PI;
            end
            else
            begin
                xf_next = -ys;
                yf_next = xs;
                zf_next = -q2e_pkg::ANG_HALF_PI;
            end
        end
        else
        begin
            xf_next = xs;
            yf_next = ys;
            zf_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cv_reg[0] <= 1'b0;
        else if (ce)
            cv_reg[0] <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            cx_reg[0] <= xf_next;
            cy_reg[0] <= yf_next;
            cz_reg[0] <= zf_next;
            c0_reg[0] <= zero1_reg;
        end
    end

    genvar i;
    generate
        for (i = 0; i < STEPS; i++)
        begin : g_step
            localparam logic signed [ZW-1:0] ANG = q2e_pkg::atan_step(i);
            logic signed [CW-1:0] dx;
            logic signed [CW-1:0] dy;

            always_comb
            begin
                dx = cy_reg[i] >>> i;
                dy = cx_reg[i] >>> i;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    cv_reg[i+1] <= 1'b0;
                else if (ce)
                    cv_reg[i+1] <= cv_reg[i];
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    c0_reg[i+1] <= c0_reg[i];
                    if (cy_reg[i] > 0)
                    begin
                        cx_reg[i+1] <= cx_reg[i] + dx;
                        cy_reg[i+1] <= cy_reg[i] - dy;
                        cz_reg[i+1] <= cz_reg[i] + ANG;
                    end
                    else
                    begin
                        cx_reg[i+1] <= cx_reg[i] - dx;
                        cy_reg[i+1] <= cy_reg[i] + dy;
                        cz_reg[i+1] <= cz_reg[i] - ANG;
                    end
                end
            end
        end
    endgenerate

    // zero vector reads as angle zero
    assign out_valid = cv_reg[STEPS];
    assign out_angle = c0_reg[STEPS] ? '0 : cz_reg[STEPS];

endmodule
